FILE: hdl/lsbx_pkg.sv
// ----------------------------------------------------------------------------
// lsbx_pkg
// Shared constants and types for the LSB length-framed extractor.
// ----------------------------------------------------------------------------
package lsbx_pkg;

  // Length header size in bytes (little-endian length field).
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned LEN_W        = 64;
  localparam int unsigned HDR_CNT_W    = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned BIT_POS_W    = 3;

  localparam logic [BIT_POS_W-1:0] LAST_BIT_POS = BIT_POS_W'(BYTE_W - 1);
  localparam logic [HDR_CNT_W-1:0] HDR_DONE     = HDR_CNT_W'(HEADER_BYTES);

  // One registered input transaction: only the sample LSB is kept.
  typedef struct packed {
    logic sof;
    logic lsb;
  } in_item_t;

  // One result from the framing logic.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

endpackage

FILE: hdl/lsbx_in_stage.sv
// ----------------------------------------------------------------------------
// lsbx_in_stage
// Input register: captures start flag and sample LSB, releases on advance.
// ----------------------------------------------------------------------------
module lsbx_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_sof,
  input  logic                in_lsb,
  input  logic                advance,
  output logic                item_valid,
  output lsbx_pkg::in_item_t  item
);

  logic               valid_r;
  logic               valid_nxt;
  lsbx_pkg::in_item_t item_r;

  // Take a new transaction whenever the held one is empty or drains this cycle.
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.sof <= in_sof;
      item_r.lsb <= in_lsb;
    end
  end

endmodule

FILE: hdl/lsbx_frame.sv
// ----------------------------------------------------------------------------
// lsbx_frame
// Bit gathering and length framing; one registered item per fire.
// ----------------------------------------------------------------------------
module lsbx_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  lsbx_pkg::in_item_t item,
  output lsbx_pkg::res_t     res
);

  logic [lsbx_pkg::BIT_POS_W-1:0] pos_r, pos_nxt;
  logic [lsbx_pkg::BYTE_W-1:0]    acc_r, acc_nxt;
  logic [lsbx_pkg::HDR_CNT_W-1:0] hdr_r, hdr_nxt;
  // Holds the assembled length during the header, then the bytes still to send.
  logic [lsbx_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic                           fin_r, fin_nxt;

  logic [lsbx_pkg::BIT_POS_W-1:0] pos_b;
  logic [lsbx_pkg::BYTE_W-1:0]    acc_b;
  logic [lsbx_pkg::HDR_CNT_W-1:0] hdr_b;
  logic [lsbx_pkg::LEN_W-1:0]     len_b;
  logic                           fin_b;
  logic [lsbx_pkg::BYTE_W-1:0]    full;

  always_comb begin
    pos_b = pos_r;
    acc_b = acc_r;
    hdr_b = hdr_r;
    len_b = len_r;
    fin_b = fin_r;
    if (item.sof) begin
      pos_b = '0;
      acc_b = '0;
      hdr_b = '0;
      len_b = '0;
      fin_b = 1'b0;
    end

    pos_nxt   = pos_b;
    acc_nxt   = acc_b;
    hdr_nxt   = hdr_b;
    len_nxt   = len_b;
    fin_nxt   = fin_b;
    full      = {acc_b[lsbx_pkg::BYTE_W-2:0], item.lsb};
    res.valid = 1'b0;
    res.data  = full;
    res.last  = 1'b0;

    if (!fin_b) begin
      if (pos_b != lsbx_pkg::LAST_BIT_POS) begin
        pos_nxt = pos_b + 1'b1;
        acc_nxt = full;
      end else begin
        pos_nxt = '0;
        acc_nxt = '0;
        if (hdr_b < lsbx_pkg::HDR_DONE) begin
          for (int i = 0; i < int'(lsbx_pkg::HEADER_BYTES); i++) begin
            if (hdr_b == lsbx_pkg::HDR_CNT_W'(i)) begin
              len_nxt[i*lsbx_pkg::BYTE_W +: lsbx_pkg::BYTE_W] = full;
            end
          end
          hdr_nxt = hdr_b + 1'b1;
          if (hdr_nxt == lsbx_pkg::HDR_DONE && len_nxt == '0) begin
            fin_nxt = 1'b1;
          end
        end else begin
          res.valid = 1'b1;
          res.last  = (len_b == lsbx_pkg::LEN_W'(1));
          len_nxt   = len_b - 1'b1;
          if (res.last) begin
            fin_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
      hdr_r <= '0;
      len_r <= '0;
      fin_r <= 1'b0;
    end else if (fire) begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      hdr_r <= hdr_nxt;
      len_r <= len_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

FILE: hdl/lsbx_out_reg.sv
// ----------------------------------------------------------------------------
// lsbx_out_reg
// Result register holding one payload byte until the sink takes it.
// ----------------------------------------------------------------------------
module lsbx_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  lsbx_pkg::res_t                res,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lsbx_pkg::BYTE_W-1:0]   out_data,
  output logic                          out_last
);

  logic                        valid_r, valid_nxt;
  logic [lsbx_pkg::BYTE_W-1:0] data_r;
  logic                        last_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res.valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data_r <= res.data;
      last_r <= res.last;
    end
  end

endmodule

FILE: hdl/lsb_length_framed_extractor_unit.sv
// ----------------------------------------------------------------------------
// lsb_length_framed_extractor_unit
// Gathers sample LSBs into bytes, reads a little-endian length header and
// streams out the framed payload bytes, last one marked.
// ----------------------------------------------------------------------------
//  channel | dir | ports                       | content
//  in_     | in  | tvalid tready tdata tuser   | tdata: sample; tuser: start of image
//  out_    | out | tvalid tready tdata tlast   | tdata: payload byte; tlast: last byte
//
// One sample per cycle when the sink is ready; an accepted sample is held in
// the input register, and its result is loaded into the result register when
// that register is free. Throughput is set by the combinational framing update
// between the input register and the result register.
// Synchronous active-low reset clears framing state, equal to a fresh frame.
// A stalled sink holds the result register and, one item later, the input.
// ----------------------------------------------------------------------------
module lsb_length_framed_extractor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] channel_sample
  input  logic       in_tuser,   // [0] start_of_image
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic       out_tlast
);

  logic               item_valid;
  lsbx_pkg::in_item_t item;
  lsbx_pkg::res_t     res;
  logic               out_free;
  logic               fire;

  assign fire = item_valid && out_free;

  lsbx_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sof     (in_tuser),
    .in_lsb     (in_tdata[0]),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  lsbx_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  lsbx_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

FILE: bench/lsb_length_framed_extractor_unit_tb.sv
// ----------------------------------------------------------------------------
// lsb_length_framed_extractor_unit_tb
// Streams channel samples into the extractor and checks every payload byte
// and its last flag against an in-bench frame predictor. Covers frames
// without a leading start, zero-length and huge-length headers, restarts in
// the middle of a byte, header or payload, and samples ignored after a
// frame. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module lsb_length_framed_extractor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned MIN_SAMPLES = 1250;
  localparam int unsigned MIN_PAYLOAD = 60;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic [lsbx_pkg::BYTE_W-1:0] data;
    logic                        last;
  } payload_exp_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // frame predictor state
  logic [lsbx_pkg::BIT_POS_W-1:0] pr_bit_pos;
  logic [lsbx_pkg::BYTE_W-1:0]    pr_acc;
  logic [lsbx_pkg::HDR_CNT_W-1:0] pr_hdr_seen;
  logic [lsbx_pkg::LEN_W-1:0]     pr_len;
  logic [lsbx_pkg::LEN_W-1:0]     pr_sent;
  logic                           pr_done;

  payload_exp_t payload_q[$];

  int err_count       = 0;
  int samples_sent    = 0;
  int frames_sent     = 0;
  int bytes_predicted = 0;
  int bytes_checked   = 0;
  int idle_cycles     = 0;
  int sink_stall      = 0;
  bit no_idle         = 1'b0;

  always #5 clk = ~clk;

  lsb_length_framed_extractor_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] channel_sample
    .in_tuser  (in_tuser),   // [0] start_of_image
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] payload_byte
    .out_tlast (out_tlast)
  );

  task automatic clear_frame_state();
    pr_bit_pos  = '0;
    pr_acc      = '0;
    pr_hdr_seen = '0;
    pr_len      = '0;
    pr_sent     = '0;
    pr_done     = 1'b0;
  endtask

  task automatic predict_sample(input logic sof, input logic [7:0] smp);
    logic [lsbx_pkg::BYTE_W-1:0] full;
    payload_exp_t                e;
    if (sof) clear_frame_state();
    if (pr_done) return;
    pr_acc = {pr_acc[lsbx_pkg::BYTE_W-2:0], smp[0]};
    if (pr_bit_pos != lsbx_pkg::LAST_BIT_POS) begin
      pr_bit_pos = pr_bit_pos + 1'b1;
      return;
    end
    full       = pr_acc;
    pr_bit_pos = '0;
    pr_acc     = '0;
    if (pr_hdr_seen < lsbx_pkg::HDR_DONE) begin
      // little-endian length: first header byte is the lowest
      pr_len      = pr_len | (lsbx_pkg::LEN_W'(full) << (8 * pr_hdr_seen));
      pr_hdr_seen = pr_hdr_seen + 1'b1;
      if (pr_hdr_seen == lsbx_pkg::HDR_DONE && pr_len == '0) pr_done = 1'b1;
      return;
    end
    pr_sent = pr_sent + 1'b1;
    e.data  = full;
    e.last  = (pr_sent == pr_len);
    if (e.last) pr_done = 1'b1;
    payload_q.push_back(e);
    bytes_predicted++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_REPORTS)
      $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_sample(input logic sof, input logic [7:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= sof;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    predict_sample(sof, smp);
    samples_sent++;
  endtask

  // one byte as eight samples, MSB first, upper sample bits random
  task automatic send_byte(input logic sof, input logic [7:0] b);
    for (int i = 7; i >= 0; i--)
      send_sample(sof && (i == 7), {7'($urandom), b[i]});
  endtask

  task automatic send_header(input logic sof, input logic [lsbx_pkg::LEN_W-1:0] len);
    for (int i = 0; i < lsbx_pkg::HEADER_BYTES; i++)
      send_byte(sof && (i == 0), len[8*i +: 8]);
  endtask

  task automatic send_frame(input logic sof, input logic [lsbx_pkg::LEN_W-1:0] len,
                            input int n_bytes);
    send_header(sof, len);
    for (int i = 0; i < n_bytes; i++) send_byte(1'b0, 8'($urandom));
    frames_sent++;
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_sample(1'b0, 8'($urandom));
  endtask

  // stop offering input, then wait for every expected byte
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (payload_q.size() != 0) @(posedge clk);
  endtask

  // reset state acts as a fresh frame; extreme payload values; trailing
  // samples after the last byte must be ignored
  task automatic test_no_start_after_reset();
    send_header(1'b0, 64'd2);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_noise(5);
    frames_sent++;
  endtask

  task automatic test_zero_length();
    send_header(1'b1, 64'd0);
    send_noise(20);
    frames_sent++;
    wait_drain();
  endtask

  task automatic test_restart_mid_frame();
    // restart inside the header and inside a byte
    send_byte(1'b1, 8'h05);
    send_byte(1'b0, 8'h00);
    send_noise(3);
    send_frame(1'b1, 64'd3, 3);
    // restart inside the payload
    send_frame(1'b1, 64'd5, 2);
    send_frame(1'b1, 64'd1, 1);
  endtask

  task automatic test_huge_length();
    send_frame(1'b1, '1, 6);
    send_frame(1'b1, {8'h80, 56'd0}, 3);
    send_frame(1'b1, 64'd1, 1);
    wait_drain();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 3; i++) send_frame(1'b1, 64'd4, 4);
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int                         kind;
    int                         len;
    logic [lsbx_pkg::LEN_W-1:0] big;
    while (samples_sent < MIN_SAMPLES || bytes_predicted < MIN_PAYLOAD) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_frame(1'b1, lsbx_pkg::LEN_W'(len), len);
        send_noise($urandom_range(0, 6));
      end else if (kind < 80) begin
        // broken frame: a start followed by arbitrary samples
        send_sample(1'b1, 8'($urandom));
        send_noise($urandom_range(0, 90));
      end else if (kind < 88) begin
        big     = {$urandom, $urandom};
        big[40] = 1'b1;
        send_frame(1'b1, big, $urandom_range(1, 6));
      end else begin
        // truncated payload, cut short by the next start
        len = $urandom_range(1, 8);
        send_frame(1'b1, lsbx_pkg::LEN_W'(len), $urandom_range(0, len - 1));
      end
      if ($urandom_range(0, 9) == 0) wait_drain();
    end
  endtask

  // sink side: random stalls, none while no_idle is set
  always @(posedge clk) begin
    if (no_idle) begin
      out_tready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      sink_stall <= pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin : check_results
    payload_exp_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (payload_q.size() == 0) begin
          report_mismatch("unexpected payload byte", out_tdata, 0);
        end else begin
          e = payload_q.pop_front();
          if (out_tdata !== e.data) report_mismatch("payload byte", out_tdata, e.data);
          if (out_tlast !== e.last) report_mismatch("last flag", out_tlast, e.last);
          bytes_checked++;
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAIL lsb_length_framed_extractor_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clear_frame_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_start_after_reset();
    test_zero_length();
    test_restart_mid_frame();
    test_huge_length();
    test_back_to_back();
    test_random_frames();

    in_tvalid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d samples in %0d frames, checked %0d payload bytes", samples_sent,
             frames_sent, bytes_checked);
    $display("Included zero and huge lengths, restarts mid-frame and ignored trailers");
    if (err_count == 0) begin
      $display("PASS lsb_length_framed_extractor_unit");
    end else begin
      $display("FAIL lsb_length_framed_extractor_unit");
    end
    $finish;
  end

endmodule
